// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top level of the log gap window deviation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define LGWD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define LGWD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== hdl/lgwd_pkg.sv =====
// Shared constants, state encoding and controller/datapath interface types.
`default_nettype none
package lgwd_pkg;

   localparam int TIME_BITS       = 32;
   localparam int LOG_FRAC_BITS   = 10;
   localparam int MAX_HALF_WINDOW = 15;
   localparam int HW_W            = 4;
   localparam int LINE_DEPTH      = 32;
   localparam int ADDR_W          = 5;
   localparam int E_W             = 5;
   localparam int LOG_W           = E_W + LOG_FRAC_BITS;
   localparam int LINE_W          = LOG_W + 1;
   localparam int CNT_W           = 5;
   localparam int SUM_W           = 20;
   localparam int IDX_W           = 16;
   localparam int SCORE_W         = 16;
   localparam int SQ_CNT_W        = 4;
   localparam int DIV_CNT_W       = 5;
   localparam int START_W         = 8;
   localparam int NOUT_W          = 5;
   localparam int LN2_Q16         = 45426;
   localparam int LN_ROUND        = 32768;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_NORM  = 11'b000_0000_0010,
      ST_SQ    = 11'b000_0000_0100,
      ST_LN    = 11'b000_0000_1000,
      ST_WRITE = 11'b000_0001_0000,
      ST_CHECK = 11'b000_0010_0000,
      ST_SUM   = 11'b000_0100_0000,
      ST_DIV   = 11'b000_1000_0000,
      ST_CRD   = 11'b001_0000_0000,
      ST_CAP   = 11'b010_0000_0000,
      ST_RSP   = 11'b100_0000_0000
   } state_type;

   typedef struct packed {
      logic first_load;
      logic gap_start;
      logic norm_step;
      logic sq_step;
      logic ln_mul;
      logic line_write;
      logic score_start;
      logic sum_step;
      logic div_start;
      logic div_step;
      logic center_rd;
      logic capture;
      logic score_taken;
   } cmd_type;

   typedef struct packed {
      logic gap_pos;
      logic item_last;
      logic norm_done;
      logic sq_last;
      logic emit_ok;
      logic sum_done;
      logic div_last;
   } status_type;

endpackage
`default_nettype wire

// ===== hdl/lgwd_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module lgwd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hdl/lgwd_ctrl.sv =====
// Controller state machine sequencing the log, window sum, divide and output steps.
`default_nettype none
module lgwd_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_last_photo,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire lgwd_pkg::status_type status,
   output lgwd_pkg::cmd_type        cmd,
   output lgwd_pkg::state_type      state
);
   import lgwd_pkg::*;

   state_type state_ff, state_in;
   logic      in_seq_ff, in_seq_in;

   always_comb begin
      state_in  = state_ff;
      in_seq_in = in_seq_ff;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!in_seq_ff) begin
                  cmd.first_load = 1'b1;
                  in_seq_in      = !req_last_photo;
               end else begin
                  cmd.gap_start = 1'b1;
                  state_in      = status.gap_pos ? ST_NORM : ST_WRITE;
               end
            end
         end
         ST_NORM: begin
            if (status.norm_done) begin
               state_in = ST_SQ;
            end else begin
               cmd.norm_step = 1'b1;
            end
         end
         ST_SQ: begin
            cmd.sq_step = 1'b1;
            if (status.sq_last) begin
               state_in = ST_LN;
            end
         end
         ST_LN: begin
            cmd.ln_mul = 1'b1;
            state_in   = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.line_write = 1'b1;
            state_in       = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.emit_ok) begin
               cmd.score_start = 1'b1;
               state_in        = ST_SUM;
            end else begin
               if (status.item_last) begin
                  in_seq_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_SUM: begin
            if (status.sum_done) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               cmd.sum_step = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_CRD;
            end
         end
         ST_CRD: begin
            cmd.center_rd = 1'b1;
            state_in      = ST_CAP;
         end
         ST_CAP: begin
            cmd.capture = 1'b1;
            state_in    = ST_RSP;
         end
         ST_RSP: begin
            if (rsp_ready) begin
               cmd.score_taken = 1'b1;
               state_in        = ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         in_seq_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         in_seq_ff <= in_seq_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RSP);
   assign state     = state_ff;
endmodule
`default_nettype wire

// ===== hdl/lgwd_dp.sv =====
// Datapath: gap, iterative fixed point log, log line memory, window sum and divider.
`default_nettype none
module lgwd_dp (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   input  wire logic [lgwd_pkg::HW_W-1:0]       csr_half_window,
   input  wire logic [lgwd_pkg::TIME_BITS-1:0]  req_time_stamp,
   input  wire logic                            req_last_photo,
   input  wire lgwd_pkg::cmd_type               cmd,
   output lgwd_pkg::status_type                 status,
   output logic [lgwd_pkg::IDX_W-1:0]           rsp_gap_index,
   output logic signed [lgwd_pkg::SCORE_W-1:0]  rsp_toc_score,
   output logic                                 rsp_score_invalid,
   output logic                                 rsp_last_score
);
   import lgwd_pkg::*;

   logic [HW_W-1:0]      hw_ff, hw_in;
   logic [HW_W-1:0]      d_ff, d_in;
   logic [TIME_BITS-1:0] prev_ff, prev_in;
   logic                 last_ff, last_in;
   logic                 pos_ff, pos_in;
   logic [31:0]          x_ff, x_in;
   logic [E_W-1:0]       e_ff, e_in;
   logic [LOG_FRAC_BITS-1:0] frac_ff, frac_in;
   logic [SQ_CNT_W-1:0]  sq_cnt_ff, sq_cnt_in;
   logic [LOG_W-1:0]     ln_ff, ln_in;
   logic [IDX_W-1:0]     gaps_ff, gaps_in;
   logic [IDX_W-1:0]     scores_ff, scores_in;
   logic [START_W-1:0]   start_ff, start_in;
   logic [NOUT_W-1:0]    nout_ff, nout_in;
   logic [HW_W-1:0]      left_ff, left_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]     k_ff, k_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [SUM_W-1:0]     num_ff, num_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 fin_ff, fin_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic signed [SCORE_W-1:0] score_ff, score_in;
   logic                 inv_ff, inv_in;

   logic [TIME_BITS-1:0] gap;
   logic [63:0]          sq_prod;
   logic [32:0]          sq_sh;
   logic [31:0]          ln_prod;
   logic [IDX_W-1:0]     pending, lag;
   logic [HW_W-1:0]      left_c, right_c;
   logic [ADDR_W-1:0]    base, sum_addr, rd_addr;
   logic [CNT_W:0]       trial;
   logic                 ge;
   logic [LINE_W-1:0]    rd_data, wr_data;
   logic [LOG_W-1:0]     rd_log;
   logic                 rd_ok;
   logic signed [SCORE_W-1:0] diff;

   assign gap     = req_time_stamp - prev_ff;
   assign sq_prod = x_ff * x_ff;
   assign sq_sh   = sq_prod[63:31];
   assign ln_prod = 32'({e_ff, frac_ff}) * 32'(LN2_Q16) + 32'(LN_ROUND);
   assign pending = gaps_ff - scores_ff;
   assign lag     = pending - 16'd1;
   assign left_c  = (start_ff < START_W'(d_ff)) ? start_ff[HW_W-1:0] : d_ff;
   assign right_c = (last_ff && (lag < IDX_W'(d_ff))) ? lag[HW_W-1:0] : d_ff;
   assign base    = scores_ff[ADDR_W-1:0] - ADDR_W'(left_ff);
   assign sum_addr = base + k_ff;
   assign rd_addr = cmd.center_rd ? scores_ff[ADDR_W-1:0] : sum_addr;
   assign trial   = {rem_ff, num_ff[SUM_W-1]};
   assign ge      = trial >= {1'b0, cnt_ff};
   assign rd_ok   = rd_data[LINE_W-1];
   assign rd_log  = rd_data[LOG_W-1:0];
   assign wr_data = {pos_ff, pos_ff ? ln_ff : LOG_W'(0)};
   assign diff    = $signed({1'b0, rd_log}) - $signed({1'b0, num_ff[LOG_W-1:0]});

   always_comb begin
      hw_in      = csr_valid ? csr_half_window : hw_ff;
      d_in       = d_ff;
      prev_in    = prev_ff;
      last_in    = last_ff;
      pos_in     = pos_ff;
      x_in       = x_ff;
      e_in       = e_ff;
      frac_in    = frac_ff;
      sq_cnt_in  = sq_cnt_ff;
      ln_in      = ln_ff;
      gaps_in    = gaps_ff;
      scores_in  = scores_ff;
      start_in   = start_ff;
      nout_in    = nout_ff;
      left_in    = left_ff;
      cnt_in     = cnt_ff;
      k_in       = k_ff;
      rd_pend_in = rd_pend_ff;
      sum_in     = sum_ff;
      num_in     = num_ff;
      rem_in     = rem_ff;
      div_cnt_in = div_cnt_ff;
      fin_in     = fin_ff;
      idx_in     = idx_ff;
      score_in   = score_ff;
      inv_in     = inv_ff;

      if (cmd.first_load) begin
         prev_in   = req_time_stamp;
         gaps_in   = '0;
         scores_in = '0;
         start_in  = '0;
      end
      if (cmd.gap_start) begin
         prev_in   = req_time_stamp;
         last_in   = req_last_photo;
         pos_in    = status.gap_pos;
         d_in      = (32'(hw_ff) > 32'(MAX_HALF_WINDOW)) ? HW_W'(MAX_HALF_WINDOW) : hw_ff;
         x_in      = gap;
         e_in      = E_W'(31);
         frac_in   = '0;
         sq_cnt_in = '0;
         nout_in   = '0;
      end
      if (cmd.norm_step) begin
         x_in = {x_ff[30:0], 1'b0};
         e_in = e_ff - E_W'(1);
      end
      if (cmd.sq_step) begin
         frac_in   = {frac_ff[LOG_FRAC_BITS-2:0], sq_sh[32]};
         x_in      = sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
         sq_cnt_in = sq_cnt_ff + SQ_CNT_W'(1);
      end
      if (cmd.ln_mul) begin
         ln_in = ln_prod[16 +: LOG_W];
      end
      if (cmd.line_write) begin
         gaps_in = gaps_ff + IDX_W'(1);
      end
      if (cmd.score_start) begin
         left_in    = left_c;
         cnt_in     = CNT_W'(left_c) + CNT_W'(right_c) + CNT_W'(1);
         k_in       = '0;
         rd_pend_in = 1'b0;
         sum_in     = '0;
         fin_in     = last_ff && (pending == IDX_W'(1));
      end
      if (cmd.sum_step) begin
         if (rd_pend_ff && rd_ok) begin
            sum_in = sum_ff + SUM_W'(rd_log);
         end
         rd_pend_in = (k_ff != cnt_ff);
         if (k_ff != cnt_ff) begin
            k_in = k_ff + CNT_W'(1);
         end
      end
      if (cmd.div_start) begin
         num_in     = sum_ff + SUM_W'(cnt_ff >> 1);
         rem_in     = '0;
         div_cnt_in = '0;
      end
      if (cmd.div_step) begin
         rem_in     = ge ? CNT_W'(trial - {1'b0, cnt_ff}) : trial[CNT_W-1:0];
         num_in     = {num_ff[SUM_W-2:0], ge};
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
      end
      if (cmd.capture) begin
         idx_in   = scores_ff;
         inv_in   = !rd_ok;
         score_in = rd_ok ? diff : {1'b1, {(SCORE_W-1){1'b0}}};
      end
      if (cmd.score_taken) begin
         scores_in = scores_ff + IDX_W'(1);
         nout_in   = nout_ff + NOUT_W'(1);
         if (start_ff != {START_W{1'b1}}) begin
            start_in = start_ff + START_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff     <= HW_W'(2);
         prev_ff   <= '0;
         gaps_ff   <= '0;
         scores_ff <= '0;
         start_ff  <= '0;
         nout_ff   <= '0;
      end else begin
         hw_ff     <= hw_in;
         prev_ff   <= prev_in;
         gaps_ff   <= gaps_in;
         scores_ff <= scores_in;
         start_ff  <= start_in;
         nout_ff   <= nout_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff       <= d_in;
      last_ff    <= last_in;
      pos_ff     <= pos_in;
      x_ff       <= x_in;
      e_ff       <= e_in;
      frac_ff    <= frac_in;
      sq_cnt_ff  <= sq_cnt_in;
      ln_ff      <= ln_in;
      left_ff    <= left_in;
      cnt_ff     <= cnt_in;
      k_ff       <= k_in;
      rd_pend_ff <= rd_pend_in;
      sum_ff     <= sum_in;
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      div_cnt_ff <= div_cnt_in;
      fin_ff     <= fin_in;
      idx_ff     <= idx_in;
      score_ff   <= score_in;
      inv_ff     <= inv_in;
   end

   lgwd_ram #(
      .WIDTH (LINE_W),
      .DEPTH (LINE_DEPTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (cmd.line_write),
      .wr_addr (gaps_ff[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      status.gap_pos   = req_time_stamp > prev_ff;
      status.item_last = last_ff;
      status.norm_done = x_ff[31];
      status.sq_last   = (sq_cnt_ff == SQ_CNT_W'(LOG_FRAC_BITS - 1));
      status.emit_ok   = (pending != '0) && !nout_ff[NOUT_W-1]
                         && (last_ff || (lag >= IDX_W'(d_ff)));
      status.sum_done  = (k_ff == cnt_ff) && !rd_pend_ff;
      status.div_last  = (div_cnt_ff == DIV_CNT_W'(SUM_W - 1));
   end

   assign rsp_gap_index     = idx_ff;
   assign rsp_toc_score     = score_ff;
   assign rsp_score_invalid = inv_ff;
   assign rsp_last_score    = fin_ff;
endmodule
`default_nettype wire

// ===== hdl/log_gap_window_deviation.sv =====
// Top level of the log gap window deviation block: controller, datapath and checks.
// Flow: a positive gap is logged and stored by a normalize loop of up to 31 single-bit shifts,
// then 10 squaring rounds on one 32x32 multiplier; each score then takes a window sum over
// the line memory read port and a 20-step divider.
// Throughput: one request at a time; the next request is taken once all its scores are gone.
// Reset: synchronous, active high; half_window returns to 2 and the block waits for a first stamp.
`default_nettype none
`include "assert_macros.svh"
module log_gap_window_deviation (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lgwd_pkg::HW_W-1:0]           csr_half_window,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [lgwd_pkg::TIME_BITS-1:0]      req_time_stamp,
   input  wire logic                                req_last_photo,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [lgwd_pkg::IDX_W-1:0]               rsp_gap_index,
   output logic signed [lgwd_pkg::SCORE_W-1:0]      rsp_toc_score,
   output logic                                     rsp_score_invalid,
   output logic                                     rsp_last_score
);
   import lgwd_pkg::*;

   cmd_type    cmd;
   status_type status;
   state_type  state;
   logic       at_min;

   // Always writable, not checked; the user must change the configuration register only while idle.
   assign csr_ready = 1'b1;

   // The controller owns the request and response handshakes and walks each request through the log,
   // store, and per-score sum, divide and output phases.
   lgwd_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_last_photo (req_last_photo),
      .req_ready      (req_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .status         (status),
      .cmd            (cmd),
      .state          (state)
   );

   // The datapath holds the stamp history, the line of log gaps and the score result.
   lgwd_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_half_window   (csr_half_window),
      .req_time_stamp    (req_time_stamp),
      .req_last_photo    (req_last_photo),
      .cmd               (cmd),
      .status            (status),
      .rsp_gap_index     (rsp_gap_index),
      .rsp_toc_score     (rsp_toc_score),
      .rsp_score_invalid (rsp_score_invalid),
      .rsp_last_score    (rsp_last_score)
   );

   // The score sits at its most negative value.
   assign at_min = (rsp_toc_score == {1'b1, {(SCORE_W-1){1'b0}}});

   // A request is never taken while a score waits at the output.
   `LGWD_ASSERT_ALWAYS(a_no_overlap, reset || !(req_ready && rsp_valid), "both channels open")
   // An invalid center always shows the minimum score, and a valid one never does.
   `LGWD_ASSERT(a_invalid_min, rsp_valid |-> (rsp_score_invalid == at_min), "bad invalid flag")
   // A request that forms a gap leaves the idle state at once.
   `LGWD_ASSERT(a_gap_busy, (cmd.gap_start) |=> !req_ready, "gap request did not start work")
   // The controller always sits in exactly one state.
   `LGWD_ASSERT(a_state_onehot, $onehot(state), "controller state not one-hot")
endmodule
`default_nettype wire
